>>> sv/pabs_pkg.sv
// ----------------------------------------------------------------------------
// pabs_pkg: shared types and constants for the parameter smoother
// Field widths, register indexes, sequencer states and the divider request.
// ----------------------------------------------------------------------------
package pabs_pkg;

  // Field and state widths
  localparam int VAL_W   = 16;                        // Q8.8 value
  localparam int ACC_W   = 24;                        // frame sum
  localparam int FT_W    = 16;                        // Q0.16 frame time
  localparam int F_W     = 17;                        // blend factor, 1.0 = 2^16
  localparam int MAX_SETS = 255;                      // sample limit per frame
  localparam int COUNT_W = $clog2(MAX_SETS + 1);
  localparam int STEP_W  = $clog2(ACC_W + 1);         // divider step counter
  localparam int PROD_W  = (ACC_W + 1) + (F_W + 1);   // signed blend product
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 2;

  localparam logic [F_W-1:0] ONE_Q16 = F_W'(65536);

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_SMOOTH_EN  = 2'd0,
    REG_GLOBAL_EN  = 2'd1,
    REG_DEFAULT    = 2'd2
  } reg_idx_t;

  // Item kinds carried in func
  localparam logic FUNC_SET = 1'b0;
  localparam logic FUNC_GET = 1'b1;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_ADD  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  // Request into the serial divider
  typedef struct packed {
    logic                     start;
    logic signed [ACC_W-1:0]  dividend;
    logic [COUNT_W-1:0]       divisor;
  } div_req_t;

endpackage

>>> sv/pabs_div.sv
// ----------------------------------------------------------------------------
// pabs_div: serial signed-by-unsigned divider
// Restoring division of the frame sum by the sample count, one quotient bit
// per cycle through a single subtractor; truncates toward zero.
// ----------------------------------------------------------------------------
module pabs_div (
  input  logic                              clk,
  input  logic                              rst,
  input  pabs_pkg::div_req_t                req,
  output logic                              done,
  output logic signed [pabs_pkg::ACC_W-1:0] quotient
);

  logic [pabs_pkg::ACC_W-1:0]    quo;
  logic [pabs_pkg::COUNT_W-1:0]  rem;
  logic [pabs_pkg::COUNT_W-1:0]  dvs;
  logic                          neg;
  logic                          busy;
  logic [pabs_pkg::STEP_W-1:0]   cnt;
  logic [pabs_pkg::COUNT_W:0]    shifted;
  logic [pabs_pkg::COUNT_W+1:0]  trial;
  logic                          ge;

  // Shared subtractor: shifted partial remainder minus divisor
  always_comb begin
    shifted = {rem, quo[pabs_pkg::ACC_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs};
    ge      = !trial[pabs_pkg::COUNT_W+1];
  end

  // Control: load on start, count down the quotient bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !req.start && busy && (cnt == pabs_pkg::STEP_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= pabs_pkg::STEP_W'(pabs_pkg::ACC_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == pabs_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath: magnitude in, one restoring step a cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      neg <= req.dividend[pabs_pkg::ACC_W-1];
      quo <= req.dividend[pabs_pkg::ACC_W-1] ? (~req.dividend + 1'b1) : req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= ge ? trial[pabs_pkg::COUNT_W-1:0] : shifted[pabs_pkg::COUNT_W-1:0];
      quo <= {quo[pabs_pkg::ACC_W-2:0], ge};
    end
  end

  // Restore the sign
  assign quotient = neg ? -$signed(quo) : $signed(quo);

endmodule

>>> sv/pabs_blend.sv
// ----------------------------------------------------------------------------
// pabs_blend: blend step toward the frame average
// Registers (average - current) * factor, then scales by 2^-16 toward zero
// and adds to the current value with 16-bit saturation.
// ----------------------------------------------------------------------------
module pabs_blend (
  input  logic                              clk,
  input  logic                              load,
  input  logic signed [pabs_pkg::ACC_W-1:0] avg,
  input  logic signed [pabs_pkg::VAL_W-1:0] cur,
  input  logic [pabs_pkg::F_W-1:0]          factor,
  output logic signed [pabs_pkg::VAL_W-1:0] blended
);

  localparam int STEP_BITS = pabs_pkg::PROD_W - 16;
  localparam int SUM_W     = STEP_BITS + 1;

  logic signed [pabs_pkg::ACC_W:0]    diff;
  logic signed [pabs_pkg::PROD_W-1:0] prod;
  logic signed [pabs_pkg::VAL_W-1:0]  cur_q;
  logic signed [STEP_BITS-1:0]        step;
  logic signed [SUM_W-1:0]            sum;

  localparam logic signed [SUM_W-1:0] VMAX = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] VMIN = -SUM_W'(32768);

  assign diff = (pabs_pkg::ACC_W+1)'(avg) - (pabs_pkg::ACC_W+1)'(cur);

  // Stage: one multiply, registered
  always_ff @(posedge clk) begin
    if (load) begin
      prod  <= pabs_pkg::PROD_W'(diff) * pabs_pkg::PROD_W'($signed({1'b0, factor}));
      cur_q <= cur;
    end
  end

  // Scale toward zero, add, saturate
  always_comb begin
    step = prod[pabs_pkg::PROD_W-1:16];
    if (prod[pabs_pkg::PROD_W-1] && (prod[15:0] != 16'd0)) begin
      step = step + 1'b1;
    end
    sum = SUM_W'(cur_q) + SUM_W'(step);
    if (sum > VMAX) begin
      blended = 16'sh7FFF;
    end else if (sum < VMIN) begin
      blended = -16'sh8000;
    end else begin
      blended = sum[pabs_pkg::VAL_W-1:0];
    end
  end

endmodule

>>> sv/param_average_blend_smoother.sv
// ----------------------------------------------------------------------------
// param_average_blend_smoother: frame-averaged, time-blended setting value
// A set item completes in the cycle it is accepted, and ready stays high.
// A get with smoothing on and samples pending passes through the serial
// divider, then the blend multiply and add, before its result is raised;
// with no samples it skips the divider, and with smoothing off it goes
// straight to delivery. Ready is low while a get is in progress, including
// while the output register stays full. Sets run one per cycle.
// Reset (synchronous, active high) clears value, sum and count, sets the
// global blend switch, and empties the output register.
// ----------------------------------------------------------------------------
module param_average_blend_smoother (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] value, [31:16] frame_time
  input  logic [1:0]  s_axis_tuser,   // [0] func, [1] force_req
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [15:0] param_value
);

  // Configuration
  logic                                smooth_en;
  logic                                global_en;
  logic signed [pabs_pkg::VAL_W-1:0]   default_value;

  // State
  pabs_pkg::state_t                    state;
  logic signed [pabs_pkg::VAL_W-1:0]   cur;
  logic signed [pabs_pkg::ACC_W-1:0]   acc;
  logic [pabs_pkg::COUNT_W-1:0]        count;
  logic [pabs_pkg::F_W-1:0]            factor;

  // Input fields
  logic                                in_func;
  logic                                in_force;
  logic signed [pabs_pkg::VAL_W-1:0]   in_value;
  logic [pabs_pkg::FT_W-1:0]           in_ft;
  logic                                accept;
  logic                                smooth_on;

  // Set path
  logic signed [pabs_pkg::ACC_W-1:0]   set_base;
  logic signed [pabs_pkg::ACC_W:0]     set_sum;
  logic signed [pabs_pkg::ACC_W-1:0]   set_acc;
  logic [pabs_pkg::FT_W+1:0]           ft_x4;

  // Units
  pabs_pkg::div_req_t                  div_req;
  logic                                div_done;
  logic signed [pabs_pkg::ACC_W-1:0]   div_q;
  logic signed [pabs_pkg::VAL_W-1:0]   blended;
  logic                                out_free;

  localparam logic signed [pabs_pkg::ACC_W:0] AMAX = (pabs_pkg::ACC_W+1)'(8388607);
  localparam logic signed [pabs_pkg::ACC_W:0] AMIN = -(pabs_pkg::ACC_W+1)'(8388608);

  assign in_value  = s_axis_tdata[15:0];
  assign in_ft     = s_axis_tdata[31:16];
  assign in_func   = s_axis_tuser[0];
  assign in_force  = s_axis_tuser[1];
  assign s_axis_tready = (state == pabs_pkg::ST_IDLE);
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign smooth_on = smooth_en && global_en;
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  // Accumulate with 24-bit saturation, seeding from the default on a new frame
  always_comb begin
    set_base = (count == '0) ? pabs_pkg::ACC_W'(default_value) : acc;
    set_sum  = (pabs_pkg::ACC_W+1)'(set_base) + (pabs_pkg::ACC_W+1)'(in_value);
    if (set_sum > AMAX) begin
      set_acc = pabs_pkg::ACC_W'(AMAX);
    end else if (set_sum < AMIN) begin
      set_acc = pabs_pkg::ACC_W'(AMIN);
    end else begin
      set_acc = set_sum[pabs_pkg::ACC_W-1:0];
    end
    ft_x4 = {in_ft, 2'b00};
  end

  // Divider request: start when a get finds pending samples
  always_comb begin
    div_req.start    = accept && (in_func == pabs_pkg::FUNC_GET) && smooth_on &&
                       (count != '0);
    div_req.dividend = acc;
    div_req.divisor  = count;
  end

  pabs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  pabs_blend u_blend (
    .clk     (clk),
    .load    (state == pabs_pkg::ST_MUL),
    .avg     (acc),
    .cur     (cur),
    .factor  (factor),
    .blended (blended)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_en     <= 1'b0;
      global_en     <= 1'b1;
      default_value <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pabs_pkg::REG_SMOOTH_EN: smooth_en     <= cfg_data[0];
        pabs_pkg::REG_GLOBAL_EN: global_en     <= cfg_data[0];
        pabs_pkg::REG_DEFAULT:   default_value <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and state update
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= pabs_pkg::ST_IDLE;
      cur           <= '0;
      acc           <= '0;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // Raise valid on delivery, drop it once the item is taken
      if ((state == pabs_pkg::ST_FIN) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        pabs_pkg::ST_IDLE: begin
          if (accept) begin
            if (in_func == pabs_pkg::FUNC_SET) begin
              if (!smooth_on) begin
                cur <= in_value;
              end else if (in_force) begin
                cur   <= in_value;
                acc   <= pabs_pkg::ACC_W'(in_value);
                count <= '0;
              end else if (count < pabs_pkg::COUNT_W'(pabs_pkg::MAX_SETS)) begin
                acc <= set_acc;
                if ((count == '0) && (default_value != '0)) begin
                  count <= pabs_pkg::COUNT_W'(2);
                end else begin
                  count <= count + 1'b1;
                end
              end
            end else if (!smooth_on) begin
              state <= pabs_pkg::ST_FIN;
            end else begin
              factor <= (ft_x4 > (pabs_pkg::FT_W+2)'(pabs_pkg::ONE_Q16)) ?
                        pabs_pkg::ONE_Q16 : ft_x4[pabs_pkg::F_W-1:0];
              state  <= (count != '0) ? pabs_pkg::ST_DIV : pabs_pkg::ST_MUL;
            end
          end
        end
        pabs_pkg::ST_DIV: begin
          // hold until the frame average is ready
          if (div_done) begin
            acc   <= div_q;
            count <= '0;
            state <= pabs_pkg::ST_MUL;
          end
        end
        pabs_pkg::ST_MUL: begin
          state <= pabs_pkg::ST_ADD;
        end
        pabs_pkg::ST_ADD: begin
          cur   <= blended;
          state <= pabs_pkg::ST_FIN;
        end
        pabs_pkg::ST_FIN: begin
          // deliver once the output register is free
          if (out_free) begin
            m_axis_tdata  <= cur;
            state         <= pabs_pkg::ST_IDLE;
          end
        end
        default: state <= pabs_pkg::ST_IDLE;
      endcase
    end
  end

  // Checks
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    count <= pabs_pkg::COUNT_W'(pabs_pkg::MAX_SETS))
    else $error("sample count above limit");

  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == pabs_pkg::ST_DIV))
    else $error("divider finished outside the divide state");

  a_set_no_result: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_func == pabs_pkg::FUNC_SET) && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("set item produced a result");

  a_get_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_func == pabs_pkg::FUNC_GET)) |=> !s_axis_tready)
    else $error("ready stayed high during a get");

endmodule

>>> sim/pabs_monitor.sv
// ----------------------------------------------------------------------------
// pabs_monitor: predicts and checks the parameter smoother results
// Watches the register port and both item channels, keeps its own copy of
// the smoothing state, and compares each returned value with the oldest
// pending get. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module pabs_monitor (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,    // [15:0] value, [31:16] frame_time
  input  logic [1:0]  s_tuser,    // [0] func, [1] force_req
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,    // [15:0] param_value
  input  logic        run_done,
  output int          mismatches = 0,
  output int          awaiting = 0
);

  // Register copies
  logic                              smooth_en;
  logic                              global_en;
  logic signed [pabs_pkg::VAL_W-1:0] seed_value;

  // Smoothing state
  logic signed [pabs_pkg::VAL_W-1:0] cur_value;
  logic signed [pabs_pkg::ACC_W-1:0] frame_sum;
  logic [pabs_pkg::COUNT_W-1:0]      sample_count;

  logic [pabs_pkg::VAL_W-1:0] expected_param[$];
  bit                         leftover_seen = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches = mismatches + 1;
  endtask

  // Fold one set item into the frame sum, or load the value directly
  function automatic void apply_set(input logic signed [pabs_pkg::VAL_W-1:0] v,
                                    input logic force_load);
    longint sum;
    if (!(smooth_en && global_en)) begin
      cur_value = v;
    end else if (force_load) begin
      cur_value    = v;
      frame_sum    = pabs_pkg::ACC_W'(v);
      sample_count = '0;
    end else if (sample_count < pabs_pkg::MAX_SETS) begin
      if (sample_count == 0) frame_sum = pabs_pkg::ACC_W'(seed_value);
      sum = longint'(frame_sum) + longint'(v);
      if (sum > 64'sd8388607) sum = 64'sd8388607;
      if (sum < -64'sd8388608) sum = -64'sd8388608;
      frame_sum = sum[pabs_pkg::ACC_W-1:0];
      if (sample_count == 0 && seed_value != 0) sample_count = pabs_pkg::COUNT_W'(2);
      else sample_count = sample_count + 1'b1;
    end
  endfunction

  // Average the frame, then blend the current value toward it
  function automatic logic [pabs_pkg::VAL_W-1:0] apply_get(
      input logic [pabs_pkg::FT_W-1:0] ft);
    longint factor, step, sum;
    if (smooth_en && global_en) begin
      if (sample_count != 0) begin
        sum          = longint'(frame_sum) / longint'(sample_count);
        frame_sum    = sum[pabs_pkg::ACC_W-1:0];
        sample_count = '0;
      end
      factor = longint'(ft) * 4;
      if (factor > longint'(pabs_pkg::ONE_Q16)) factor = longint'(pabs_pkg::ONE_Q16);
      step = (longint'(frame_sum) - longint'(cur_value)) * factor
             / longint'(pabs_pkg::ONE_Q16);
      sum = longint'(cur_value) + step;
      if (sum > 64'sd32767) sum = 64'sd32767;
      if (sum < -64'sd32768) sum = -64'sd32768;
      cur_value = sum[pabs_pkg::VAL_W-1:0];
    end
    return cur_value;
  endfunction

  always @(posedge clk) begin
    logic [pabs_pkg::VAL_W-1:0] want;
    if (rst) begin
      smooth_en    = 1'b0;
      global_en    = 1'b1;
      seed_value   = '0;
      cur_value    = '0;
      frame_sum    = '0;
      sample_count = '0;
      expected_param.delete();
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          pabs_pkg::REG_SMOOTH_EN: smooth_en  = cfg_data[0];
          pabs_pkg::REG_GLOBAL_EN: global_en  = cfg_data[0];
          pabs_pkg::REG_DEFAULT:   seed_value = cfg_data;
          default: ;
        endcase
      end
      // Predict each accepted input item
      if (s_tvalid && s_tready) begin
        if (s_tuser[0] == pabs_pkg::FUNC_SET) begin
          apply_set(s_tdata[15:0], s_tuser[1]);
        end else begin
          want = apply_get(s_tdata[31:16]);
          expected_param = {expected_param, want};
        end
      end
      // Compare each accepted result with the oldest pending get
      if (m_tvalid && m_tready) begin
        if (expected_param.size() == 0) begin
          report_mismatch($sformatf("param_value %h with no get pending", m_tdata));
        end else begin
          want = expected_param.pop_front();
          if (m_tdata !== want)
            report_mismatch($sformatf("param_value %h, expected %h", m_tdata, want));
        end
      end
      // Flag gets that never returned
      if (run_done && !leftover_seen) begin
        leftover_seen = 1'b1;
        if (expected_param.size() != 0)
          report_mismatch($sformatf("%0d gets never returned", expected_param.size()));
      end
    end
    awaiting <= expected_param.size();
  end

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the parameter smoother
// Runs a directed pass over the value and frame time extremes, forced and
// plain sets, empty frames and both smoothing switches, then random frames
// of sets closed by a get under a series of register settings, with random
// idle gaps on the input and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb;

  localparam int     RANDOM_ITEMS  = 1250;
  localparam int     SETTLE_CYCLES = 32;
  localparam longint TIMEOUT_UNITS = 40_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        run_done = 1'b0;

  int mismatches;
  int awaiting;
  int items_sent = 0;
  int gets_sent = 0;
  int settings_used = 1;
  bit quiet = 1'b0;
  int stall_left = 0;

  always #5 clk = ~clk;

  param_average_blend_smoother i_dut (.*);

  pabs_monitor i_monitor (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_axis_tvalid),
    .s_tready   (s_axis_tready),
    .s_tdata    (s_axis_tdata),
    .s_tuser    (s_axis_tuser),
    .m_tvalid   (m_axis_tvalid),
    .m_tready   (m_axis_tready),
    .m_tdata    (m_axis_tdata),
    .run_done   (run_done),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  // Mostly short gaps, a few long ones, none in quiet phases
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_frame_time();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h4000;
      3: return 16'h3FFF;
      4, 5: return 16'($urandom_range(0, 16384));
      default: return 16'($urandom);
    endcase
  endfunction

  // Present one item and hold it until accepted
  task automatic send_item(input logic func, input logic [15:0] value,
                           input logic force_req, input logic [15:0] ft,
                           input bit counted);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ft, value};
    s_axis_tuser  <= {force_req, func};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (counted) items_sent++;
    if (func == pabs_pkg::FUNC_GET) gets_sent++;
  endtask

  // Drop valid, wait for every pending get, then let the block go idle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input pabs_pkg::reg_idx_t idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One frame: a run of sets closed by a get
  task automatic run_frame(input int n_sets, input bit allow_force);
    logic force_req;
    for (int i = 0; i < n_sets; i++) begin
      force_req = allow_force && ($urandom_range(0, 9) == 0);
      send_item(pabs_pkg::FUNC_SET, rand_value(), force_req, 16'($urandom),
                i < pabs_pkg::MAX_SETS - 1);
    end
    send_item(pabs_pkg::FUNC_GET, rand_value(), 1'($urandom), rand_frame_time(), 1'b1);
  endtask

  // Result side: random stalls
  initial begin
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Stimulus
  initial begin
    int   phase;
    int   phase_end;
    logic smooth_sel, global_sel;
    logic [15:0] seed_sel;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Smoothing off after reset: sets write through
    send_item(pabs_pkg::FUNC_SET, 16'h7FFF, 1'b0, 16'h0000, 1'b0);
    send_item(pabs_pkg::FUNC_GET, 16'h0000, 1'b0, 16'h0000, 1'b0);
    send_item(pabs_pkg::FUNC_SET, 16'h8000, 1'b1, 16'hFFFF, 1'b0);
    send_item(pabs_pkg::FUNC_GET, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0);

    // Smoothing on, zero default: forced load, averaging, empty frame
    settle();
    write_reg(pabs_pkg::REG_SMOOTH_EN, 16'h0001);
    send_item(pabs_pkg::FUNC_SET, 16'h7FFF, 1'b1, 16'h0000, 1'b0);
    send_item(pabs_pkg::FUNC_GET, 16'h0000, 1'b0, 16'h0000, 1'b0);
    send_item(pabs_pkg::FUNC_SET, 16'h8000, 1'b0, 16'h0000, 1'b0);
    send_item(pabs_pkg::FUNC_SET, 16'h8000, 1'b0, 16'hFFFF, 1'b0);
    send_item(pabs_pkg::FUNC_GET, 16'h0000, 1'b0, 16'hFFFF, 1'b0);
    send_item(pabs_pkg::FUNC_GET, 16'h0000, 1'b0, 16'h4000, 1'b0);
    send_item(pabs_pkg::FUNC_SET, 16'h0100, 1'b0, 16'h0000, 1'b0);
    send_item(pabs_pkg::FUNC_GET, 16'h0000, 1'b0, 16'h0001, 1'b0);

    // Nonzero default seeds the frame and counts as a sample
    settle();
    write_reg(pabs_pkg::REG_DEFAULT, 16'h8000);
    send_item(pabs_pkg::FUNC_SET, 16'h7FFF, 1'b0, 16'h0000, 1'b0);
    send_item(pabs_pkg::FUNC_SET, 16'h7FFF, 1'b0, 16'h0000, 1'b0);
    send_item(pabs_pkg::FUNC_GET, 16'h0000, 1'b0, 16'h4000, 1'b0);
    settle();
    write_reg(pabs_pkg::REG_DEFAULT, 16'h7FFF);
    send_item(pabs_pkg::FUNC_SET, 16'h8000, 1'b0, 16'h0000, 1'b0);
    send_item(pabs_pkg::FUNC_GET, 16'h0000, 1'b0, 16'h2000, 1'b0);
    send_item(pabs_pkg::FUNC_GET, 16'h0000, 1'b0, 16'h3FFF, 1'b0);

    // Global switch off overrides the per-value enable
    settle();
    write_reg(pabs_pkg::REG_GLOBAL_EN, 16'h0000);
    send_item(pabs_pkg::FUNC_SET, 16'h1234, 1'b0, 16'h0000, 1'b0);
    send_item(pabs_pkg::FUNC_GET, 16'h0000, 1'b0, 16'h4000, 1'b0);
    send_item(pabs_pkg::FUNC_SET, 16'h8000, 1'b1, 16'hFFFF, 1'b0);
    send_item(pabs_pkg::FUNC_GET, 16'h0000, 1'b0, 16'h0000, 1'b0);
    settings_used = 5;

    // Random frames under a rotation of register settings
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      settle();
      case (phase % 8)
        0: begin smooth_sel = 1'b1; global_sel = 1'b1; seed_sel = 16'h0000; end
        1: begin smooth_sel = 1'b1; global_sel = 1'b1; seed_sel = rand_value(); end
        2: begin smooth_sel = 1'b1; global_sel = 1'b1; seed_sel = 16'h8000; end
        3: begin smooth_sel = 1'b1; global_sel = 1'b1; seed_sel = 16'h7FFF; end
        4: begin smooth_sel = 1'b0; global_sel = 1'b1; seed_sel = rand_value(); end
        5: begin smooth_sel = 1'b1; global_sel = 1'b0; seed_sel = rand_value(); end
        6: begin
          smooth_sel = 1'b1;
          global_sel = 1'b1;
          seed_sel   = 16'($urandom_range(0, 255)) - 16'd128;
        end
        default: begin smooth_sel = 1'b0; global_sel = 1'b0; seed_sel = rand_value(); end
      endcase
      write_reg(pabs_pkg::REG_SMOOTH_EN, {15'd0, smooth_sel});
      write_reg(pabs_pkg::REG_GLOBAL_EN, {15'd0, global_sel});
      write_reg(pabs_pkg::REG_DEFAULT, seed_sel);
      settings_used++;
      quiet = (phase % 3 == 2);

      // Overfill one frame past the sample limit
      if (phase == 0 || phase == 3) run_frame($urandom_range(256, 290), 1'b0);

      phase_end = items_sent + 120;
      while (items_sent < phase_end && items_sent < RANDOM_ITEMS) begin
        if ($urandom_range(0, 4) == 0)
          send_item(1'($urandom), 16'($urandom), 1'($urandom), 16'($urandom), 1'b1);
        else if ($urandom_range(0, 99) < 2)
          run_frame($urandom_range(240, 290), 1'b0);
        else
          run_frame($urandom_range(0, 6), 1'b1);
      end
      phase++;
    end

    // Drain, then close the run
    settle();
    quiet = 1'b1;
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    $display("covered %0d random items plus a directed pass, %0d gets in all", items_sent,
             gets_sent);
    $display("register settings applied: %0d, with sample-limit frames included",
             settings_used);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_UNITS);
    $display("simulation failed");
    $finish;
  end

endmodule
